// File: rtl/core/record_slot_allocator_locator_unit_assert.svh
// assertion macros used by the checker file
`ifndef RECORD_SLOT_ALLOCATOR_LOCATOR_UNIT_ASSERT_SVH
`define RECORD_SLOT_ALLOCATOR_LOCATOR_UNIT_ASSERT_SVH

// clocked property, held off while reset is asserted
`define RSAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked through reset as well
`define RSAL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rsal_pkg.sv
package rsal_pkg;

    // field widths
    localparam int SLOT_W     = 10;
    localparam int LEN_W      = 13;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int SECTOR_W   = 14;
    localparam int BYTE_OFF_W = 9;
    // byte offset in the file: 10-bit slot times 13-bit length plus header
    localparam int OFF_W      = 24;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_OFFSET,
        S_QUOT,
        S_REMN,
        S_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic decide;
        logic offset_mul;
        logic quot_mul;
        logic remn_mul;
        logic finish;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic locate;
    } stat_t;

endpackage

// File: rtl/core/rsal_ram.sv
module rsal_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rsal_ctrl.sv
module rsal_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rsal_pkg::stat_t stat,
    output rsal_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);

    import rsal_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.decide = 1'b1;
                state_next = stat.locate ? S_OFFSET : S_FINISH;
            end
            S_OFFSET:
            begin
                cmd.offset_mul = 1'b1;
                state_next     = S_QUOT;
            end
            S_QUOT:
            begin
                cmd.quot_mul = 1'b1;
                state_next   = S_REMN;
            end
            S_REMN:
            begin
                cmd.remn_mul = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/core/rsal_dpath.sv
module rsal_dpath #(
    parameter int MAX_SLOTS    = 1024,
    parameter int SECTOR_BYTES = 512,
    parameter int HEADER_BYTES = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rsal_pkg::cmd_t                  cmd,
    output rsal_pkg::stat_t                 stat,
    input  logic [rsal_pkg::OP_W-1:0]       op,
    input  logic [rsal_pkg::SLOT_W-1:0]     slot_number,
    input  logic                            cfg_we,
    input  logic [rsal_pkg::LEN_W-1:0]      record_length,
    output logic [rsal_pkg::SLOT_W-1:0]     slot_out,
    output logic [rsal_pkg::STATUS_W-1:0]   status,
    output logic [rsal_pkg::SECTOR_W-1:0]   sector,
    output logic [rsal_pkg::BYTE_OFF_W-1:0] byte_offset
);

    import rsal_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SLOTS);
    localparam int HW_W   = $clog2(MAX_SLOTS + 1);
    localparam int RCP_W  = OFF_W + 1;
    localparam int QP_W   = OFF_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << OFF_W) / SECTOR_BYTES);
    localparam logic [OFF_W-1:0] SB_V  = OFF_W'(SECTOR_BYTES);
    localparam logic [OFF_W-1:0] HDR_V = OFF_W'(HEADER_BYTES);

    // allocator state
    logic [SLOT_W-1:0]   free_head_reg, free_head_next;
    logic [HW_W-1:0]     high_water_reg, high_water_next;
    logic [LEN_W-1:0]    rec_len_reg, rec_len_next;

    // item and result registers
    logic [OP_W-1:0]       op_reg, op_next;
    logic [SLOT_W-1:0]     slot_in_reg, slot_in_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  locate_reg, locate_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic [QP_W-1:0]       qprod_reg, qprod_next;
    logic [OFF_W-1:0]      q_reg, q_next;
    logic [OFF_W-1:0]      qd_reg, qd_next;
    logic [SLOT_W-1:0]     slot_out_reg, slot_out_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SECTOR_W-1:0]   sector_reg, sector_next;
    logic [BYTE_OFF_W-1:0] byte_off_reg, byte_off_next;

    // decision
    logic                  head_ok, hw_ok, slot_ok;
    logic [SLOT_W-1:0]     dec_slot, dec_head;
    logic [STATUS_W-1:0]   dec_status;
    logic                  dec_locate, dec_push;
    logic [HW_W-1:0]       dec_hw;

    // link memory
    logic                     ram_we;
    logic [ADDR_W+SLOT_W-1:0] raddr_wide, waddr_wide;
    logic [SLOT_W-1:0]        ram_rdata;

    // remainder correction
    logic [SLOT_W-1:0] slot_m1;
    logic [OFF_W-1:0]  remn;
    logic [OFF_W-1:0]  quot_fix, remn_fix;

    assign raddr_wide = {{ADDR_W{1'b0}}, free_head_reg};
    assign waddr_wide = {{ADDR_W{1'b0}}, slot_in_reg};

    rsal_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_wide[ADDR_W-1:0]),
        .wdata (free_head_reg),
        .raddr (raddr_wide[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // range checks
    assign head_ok = (free_head_reg != '0) && (32'(free_head_reg) < 32'(MAX_SLOTS));
    assign hw_ok   = (32'(high_water_reg) < 32'(MAX_SLOTS));
    assign slot_ok = (slot_in_reg != '0)
                     && (32'(slot_in_reg) < 32'(high_water_reg))
                     && (32'(slot_in_reg) < 32'(MAX_SLOTS));

    // pop, bump, push or reject
    always_comb
    begin
        dec_slot   = slot_in_reg;
        dec_status = ST_OK;
        dec_locate = 1'b1;
        dec_head   = free_head_reg;
        dec_hw     = high_water_reg;
        dec_push   = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            if (head_ok)
            begin
                dec_slot = free_head_reg;
                dec_head = ram_rdata;
            end
            else if (hw_ok)
            begin
                dec_slot = SLOT_W'(high_water_reg);
                dec_hw   = high_water_reg + HW_W'(1);
            end
            else
            begin
                dec_slot   = '0;
                dec_status = ST_FULL;
                dec_locate = 1'b0;
            end
        end
        else if (!slot_ok)
        begin
            dec_status = ST_RANGE;
            dec_locate = 1'b0;
        end
        else if (op_reg == OP_RELEASE)
        begin
            dec_push = 1'b1;
            dec_head = slot_in_reg;
        end
    end

    assign stat.locate = dec_locate;

    // state updates
    always_comb
    begin
        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;
        rec_len_next    = rec_len_reg;
        ram_we          = 1'b0;
        if (cmd.decide)
        begin
            free_head_next  = dec_head;
            high_water_next = dec_hw;
            ram_we          = dec_push;
        end
        if (cfg_we)
        begin
            rec_len_next = record_length;
        end
    end

    // location arithmetic
    assign slot_m1 = res_slot_reg - SLOT_W'(1);
    assign remn    = offset_reg - qd_reg;

    always_comb
    begin
        if (remn >= SB_V)
        begin
            quot_fix = q_reg + OFF_W'(2);
            remn_fix = remn - SB_V;
        end
        else
        begin
            quot_fix = q_reg + OFF_W'(1);
            remn_fix = remn;
        end
    end

    always_comb
    begin
        op_next         = cmd.load ? op : op_reg;
        slot_in_next    = cmd.load ? slot_number : slot_in_reg;
        res_slot_next   = cmd.decide ? dec_slot : res_slot_reg;
        res_status_next = cmd.decide ? dec_status : res_status_reg;
        locate_next     = cmd.decide ? dec_locate : locate_reg;
        offset_next     = cmd.offset_mul
                          ? (OFF_W'(slot_m1) * OFF_W'(rec_len_reg)) + HDR_V
                          : offset_reg;
        qprod_next      = cmd.quot_mul
                          ? {{RCP_W{1'b0}}, offset_reg} * {{OFF_W{1'b0}}, RECIP}
                          : qprod_reg;
        q_next          = cmd.remn_mul ? qprod_reg[2*OFF_W-1:OFF_W] : q_reg;
        qd_next         = cmd.remn_mul ? qprod_reg[2*OFF_W-1:OFF_W] * SB_V : qd_reg;
        slot_out_next   = slot_out_reg;
        status_next     = status_reg;
        sector_next     = sector_reg;
        byte_off_next   = byte_off_reg;
        if (cmd.finish)
        begin
            slot_out_next = res_slot_reg;
            status_next   = res_status_reg;
            sector_next   = locate_reg ? quot_fix[SECTOR_W-1:0] : '0;
            byte_off_next = locate_reg ? remn_fix[BYTE_OFF_W-1:0] : '0;
        end
    end

    // allocator state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            high_water_reg <= HW_W'(1);
            rec_len_reg    <= LEN_RESET;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            high_water_reg <= high_water_next;
            rec_len_reg    <= rec_len_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        slot_in_reg    <= slot_in_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        locate_reg     <= locate_next;
        offset_reg     <= offset_next;
        qprod_reg      <= qprod_next;
        q_reg          <= q_next;
        qd_reg         <= qd_next;
        slot_out_reg   <= slot_out_next;
        status_reg     <= status_next;
        sector_reg     <= sector_next;
        byte_off_reg   <= byte_off_next;
    end

    assign slot_out    = slot_out_reg;
    assign status      = status_reg;
    assign sector      = sector_reg;
    assign byte_offset = byte_off_reg;

endmodule

// File: rtl/core/record_slot_allocator_locator_unit.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------------
// command   | start, busy                | op, slot_number
// result    | done (one-cycle strobe)    | slot_out, status, sector, byte_offset
// config    | cfg_valid, cfg_ready       | record_length
//
// a command is taken when start is high and busy is low; a rejected or full command
// goes from the lookup state straight to finish, while a located slot also passes
// through the offset, quotient and remainder states; busy drops in the cycle done
// rises, so commands run one at a time. the states cover the free-list link memory read
// and the multiply chain for the offset, the sector quotient and its remainder check.
// reset clears the free list and sets the high-water mark to one; the link memory
// needs no clearing; the result has no back-pressure and cfg_ready is always high.
module record_slot_allocator_locator_unit #(
    parameter int MAX_SLOTS    = 1024,
    parameter int SECTOR_BYTES = 512,
    parameter int HEADER_BYTES = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rsal_pkg::OP_W-1:0]       op,
    input  logic [rsal_pkg::SLOT_W-1:0]     slot_number,
    output logic                            done,
    output logic [rsal_pkg::SLOT_W-1:0]     slot_out,
    output logic [rsal_pkg::STATUS_W-1:0]   status,
    output logic [rsal_pkg::SECTOR_W-1:0]   sector,
    output logic [rsal_pkg::BYTE_OFF_W-1:0] byte_offset,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsal_pkg::LEN_W-1:0]      record_length
);

    import rsal_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  ctrl_busy;

    assign cfg_ready = 1'b1;
    assign busy      = ctrl_busy;

    // sequencer
    rsal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy),
        .done  (done)
    );

    // free list, counters and location arithmetic
    rsal_dpath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .SECTOR_BYTES (SECTOR_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .slot_number   (slot_number),
        .cfg_we        (cfg_valid & cfg_ready),
        .record_length (record_length),
        .slot_out      (slot_out),
        .status        (status),
        .sector        (sector),
        .byte_offset   (byte_offset)
    );

endmodule

// File: rtl/core/rsal_checker.sv
`include "record_slot_allocator_locator_unit_assert.svh"

module rsal_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [rsal_pkg::STATUS_W-1:0]   status,
    input logic [rsal_pkg::SECTOR_W-1:0]   sector,
    input logic [rsal_pkg::BYTE_OFF_W-1:0] byte_offset
);

    import rsal_pkg::*;

    // a result strobe only comes once the unit is free again
    `RSAL_ASSERT_ALWAYS(a_done_not_busy, done |-> !busy, "done while busy")

    // a taken transaction keeps the unit busy in the next cycle
    `RSAL_ASSERT(a_accept_busy, (start && !busy) |=> busy, "not busy after accept")

    // no result in the cycle right after a transaction is taken
    `RSAL_ASSERT(a_accept_no_done, (start && !busy) |=> !done, "result too early")

    // status is one of the defined codes
    `RSAL_ASSERT(a_status_code, done |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL), "bad status code")

    // a rejected or full result carries no location
    `RSAL_ASSERT(a_reject_no_loc, (done && status != ST_OK) |-> (sector == '0 && byte_offset == '0), "location on reject")

endmodule

bind record_slot_allocator_locator_unit rsal_checker u_rsal_checker (.*);
